### src/tccc_pkg.sv
// Shared types, constants and color packing for the text console cursor controller.
package tccc_pkg;

    localparam int TEXT_COLS_DEF = 128;
    localparam int TEXT_ROWS_DEF = 48;

    localparam int SHIFT_W = 5;
    localparam int PIX_W   = 32;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        CMD_PUT        = 2'd0,
        CMD_BACKSPACE  = 2'd1,
        CMD_SET_CURSOR = 2'd2,
        CMD_CLEAR      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        EV_WRITE  = 2'd0,
        EV_SCROLL = 2'd1,
        EV_CLEAR  = 2'd2
    } t_event_kind;

    localparam logic [1:0] REG_RED   = 2'd0;
    localparam logic [1:0] REG_GREEN = 2'd1;
    localparam logic [1:0] REG_BLUE  = 2'd2;

    localparam logic [SHIFT_W-1:0] RED_SHIFT_RST   = 5'd16;
    localparam logic [SHIFT_W-1:0] GREEN_SHIFT_RST = 5'd8;
    localparam logic [SHIFT_W-1:0] BLUE_SHIFT_RST  = 5'd0;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;

    localparam logic [3:0] PAL_BLACK = 4'd0;
    localparam logic [3:0] PAL_WHITE = 4'd15;

    localparam logic [23:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [7:0]  chr;
        logic [3:0]  fg_idx;
        logic [3:0]  bg_idx;
        logic        last;
    } t_event;

    // Bits shifted past the top of the pixel word are dropped.
    function automatic logic [PIX_W-1:0] pack_color(
        input logic [3:0]         idx,
        input logic [SHIFT_W-1:0] rs,
        input logic [SHIFT_W-1:0] gs,
        input logic [SHIFT_W-1:0] bs
    );
        logic [23:0] rgb;
        rgb = PALETTE[idx];
        return (PIX_W'(rgb[23:16]) << rs) | (PIX_W'(rgb[15:8]) << gs) |
               (PIX_W'(rgb[7:0]) << bs);
    endfunction

endpackage

### src/text_console_cursor_controller.sv
// Top level of the teletype-style cursor controller for a character-cell console.
// Each request is handled as it is accepted: the cursor update and the events it
// causes are worked out from the request and the cursor registers and written into a
// four-entry event queue in the same cycle, so a new request can be accepted every
// cycle while the queue holds at most two events. A printable character that makes
// the screen scroll yields two events, which leave the queue one at a time, so
// such requests are held back by the event stream; other requests run at one per
// cycle while the queue has room. Pixel words are packed from the palette on exit.
module text_console_cursor_controller #(
    parameter int TEXT_COLS = tccc_pkg::TEXT_COLS_DEF,
    parameter int TEXT_ROWS = tccc_pkg::TEXT_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // APB configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tccc_pkg::APB_AW-1:0] paddr,
    input  logic [tccc_pkg::APB_DW-1:0] pwdata,
    output logic [tccc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    // Request stream.
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,  // character, color_attr, new_col, new_row
    input  logic [1:0]                  s_axis_tuser,  // command
    // Event stream.
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [87:0]                 m_axis_tdata,  // cell_col, cell_row, cell_char, fg_pixel, bg_pixel
    output logic [1:0]                  m_axis_tuser,  // event_kind
    output logic                        m_axis_tlast   // last
);

    localparam int COL_W = $clog2(TEXT_COLS);
    localparam int ROW_W = $clog2(TEXT_ROWS);
    localparam logic [COL_W:0]   COLS_V   = (COL_W+1)'(TEXT_COLS);
    localparam logic [ROW_W:0]   ROWS_V   = (ROW_W+1)'(TEXT_ROWS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(TEXT_COLS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TEXT_ROWS - 1);
    localparam int CNT_W = tccc_pkg::QUEUE_AW + 1;

    logic [tccc_pkg::SHIFT_W-1:0] r_red_shift, r_green_shift, r_blue_shift;
    logic [COL_W-1:0]             r_col, n_col;
    logic [ROW_W-1:0]             r_row, n_row;
    tccc_pkg::t_event             r_queue [tccc_pkg::QUEUE_DEPTH];
    logic [tccc_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]             r_count, n_count;

    tccc_pkg::t_cmd   cmd;
    tccc_pkg::t_event ev0, ev1, head;
    logic [1:0]       ev_num;
    logic [7:0]       in_char, in_attr, in_new_col, in_new_row;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic             is_newline, row_adv, overflow;
    logic             push, pop, cfg_wr;

    assign cmd        = tccc_pkg::t_cmd'(s_axis_tuser);
    assign in_char    = s_axis_tdata[7:0];
    assign in_attr    = s_axis_tdata[15:8];
    assign in_new_col = s_axis_tdata[23:16];
    assign in_new_row = s_axis_tdata[31:24];

    assign col_inc    = {1'b0, r_col} + 1'b1;
    assign row_inc    = {1'b0, r_row} + 1'b1;
    assign is_newline = (in_char == tccc_pkg::CHAR_NEWLINE);
    assign row_adv    = is_newline || (col_inc >= COLS_V);
    assign overflow   = row_adv && (row_inc >= ROWS_V);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        ev_num = 2'd0;
        ev0    = '0;
        ev1    = '0;
        ev1.kind = tccc_pkg::EV_SCROLL;
        ev1.last = 1'b1;
        case (cmd)
            tccc_pkg::CMD_PUT: begin
                n_col = row_adv ? '0 : col_inc[COL_W-1:0];
                n_row = overflow ? LAST_ROW : (row_adv ? row_inc[ROW_W-1:0] : r_row);
                if (is_newline) begin
                    ev0.kind = tccc_pkg::EV_SCROLL;
                    ev0.last = 1'b1;
                    ev_num   = {1'b0, overflow};
                end else begin
                    ev0.kind   = tccc_pkg::EV_WRITE;
                    ev0.col    = 8'(r_col);
                    ev0.row    = 8'(r_row);
                    ev0.chr    = in_char;
                    ev0.fg_idx = in_attr[3:0];
                    ev0.bg_idx = in_attr[7:4];
                    ev0.last   = !overflow;
                    ev_num     = overflow ? 2'd2 : 2'd1;
                end
            end
            tccc_pkg::CMD_BACKSPACE: begin
                if (r_col != '0) begin
                    n_col = r_col - 1'b1;
                end else if (r_row != '0) begin
                    n_col = LAST_COL;
                    n_row = r_row - 1'b1;
                end
                ev0.kind   = tccc_pkg::EV_WRITE;
                ev0.col    = 8'(n_col);
                ev0.row    = 8'(n_row);
                ev0.chr    = tccc_pkg::CHAR_SPACE;
                ev0.fg_idx = tccc_pkg::PAL_WHITE;
                ev0.bg_idx = tccc_pkg::PAL_BLACK;
                ev0.last   = 1'b1;
                ev_num     = 2'd1;
            end
            tccc_pkg::CMD_SET_CURSOR: begin
                n_col = (in_new_col > 8'(TEXT_COLS - 1)) ? LAST_COL : in_new_col[COL_W-1:0];
                n_row = (in_new_row > 8'(TEXT_ROWS - 1)) ? LAST_ROW : in_new_row[ROW_W-1:0];
            end
            tccc_pkg::CMD_CLEAR: begin
                n_col    = '0;
                n_row    = '0;
                ev0.kind = tccc_pkg::EV_CLEAR;
                ev0.last = 1'b1;
                ev_num   = 2'd1;
            end
            default: begin
                n_col = r_col;
            end
        endcase
    end

    assign s_axis_tready = (r_count <= CNT_W'(tccc_pkg::QUEUE_DEPTH - 2));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_count != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign n_count       = CNT_W'(r_count + (push ? CNT_W'(ev_num) : CNT_W'(0)) - CNT_W'(pop));

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_shift   <= tccc_pkg::RED_SHIFT_RST;
            r_green_shift <= tccc_pkg::GREEN_SHIFT_RST;
            r_blue_shift  <= tccc_pkg::BLUE_SHIFT_RST;
            r_col         <= '0;
            r_row         <= '0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    tccc_pkg::REG_RED:   r_red_shift   <= pwdata[tccc_pkg::SHIFT_W-1:0];
                    tccc_pkg::REG_GREEN: r_green_shift <= pwdata[tccc_pkg::SHIFT_W-1:0];
                    tccc_pkg::REG_BLUE:  r_blue_shift  <= pwdata[tccc_pkg::SHIFT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (push) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_wr_ptr <= r_wr_ptr + tccc_pkg::QUEUE_AW'(ev_num);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && ev_num != 2'd0) begin
            r_queue[r_wr_ptr] <= ev0;
        end
        if (push && ev_num == 2'd2) begin
            r_queue[r_wr_ptr + 1'b1] <= ev1;
        end
    end

    always_comb begin
        case (paddr[3:2])
            tccc_pkg::REG_RED:   prdata = tccc_pkg::APB_DW'(r_red_shift);
            tccc_pkg::REG_GREEN: prdata = tccc_pkg::APB_DW'(r_green_shift);
            tccc_pkg::REG_BLUE:  prdata = tccc_pkg::APB_DW'(r_blue_shift);
            default:             prdata = '0;
        endcase
    end

    assign head = r_queue[r_rd_ptr];
    assign m_axis_tdata = {
        tccc_pkg::pack_color(head.bg_idx, r_red_shift, r_green_shift, r_blue_shift),
        tccc_pkg::pack_color(head.fg_idx, r_red_shift, r_green_shift, r_blue_shift),
        head.chr, head.row, head.col
    };
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

### src/tccc_checker.sv
// Port-level checker for the text console cursor controller and its bind statement.
module tccc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("event stream valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled event changed");

    a_set_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
        s_axis_tuser == tccc_pkg::CMD_SET_CURSOR |=> !m_axis_tvalid)
        else $error("set cursor request produced an event");

    a_clear_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
        s_axis_tuser == tccc_pkg::CMD_CLEAR |=>
        m_axis_tvalid && m_axis_tuser == tccc_pkg::EV_CLEAR && m_axis_tlast)
        else $error("clear request did not produce a final clear event");

    a_blank_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != tccc_pkg::EV_WRITE |-> m_axis_tdata == '0)
        else $error("scroll or clear event carries nonzero fields");

endmodule

bind text_console_cursor_controller tccc_checker u_tccc_checker (.*);
